[hw/rtl/clas_pkg.sv]
// ----------------------------------------------------------------------------
// clas_pkg: shared types and constants for the command line argument splitter
// Holds the input and result word layouts and the special code units.
// ----------------------------------------------------------------------------
package clas_pkg;

    // special UTF-16 code units
    localparam logic [15:0] CU_SPACE  = 16'h0020;
    localparam logic [15:0] CU_TAB    = 16'h0009;
    localparam logic [15:0] CU_QUOTE  = 16'h0022;
    localparam logic [15:0] CU_BSLASH = 16'h005C;

    // saturation limit of the backslash run
    localparam logic [15:0] RUN_MAX = 16'hFFFF;

    // input word: one code unit or the end-of-line mark
    typedef struct packed {
        logic [15:0] code_unit;
        logic        line_end;
    } t_in_word;

    // result word: backslashes, optional char, end marks
    typedef struct packed {
        logic [15:0] backslash_count;
        logic        has_char;
        logic [15:0] out_char;
        logic        arg_done;
        logic        line_done;
    } t_out_word;

endpackage

[hw/rtl/clas_stream_if.sv]
// ----------------------------------------------------------------------------
// clas_stream_if: valid/ready stream channel
// Carries one payload word per handshake; source drives, sink accepts.
// ----------------------------------------------------------------------------
interface clas_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/command_line_argument_splitter.sv]
// ----------------------------------------------------------------------------
// command_line_argument_splitter: MSVCRT-style argument splitting
//
// i_in carries one word per handshake: a UTF-16 code unit, or line_end = 1
// to close the command line. o_out carries result words: a count of literal
// backslashes to append, an optional character, and end-of-argument and
// end-of-line marks. A word that appends and ends nothing gives no result.
//
// Throughput: one input word per cycle while the skid entry is empty. The
// parse step is a single layer of compare/select logic on the parser state
// (quote flags, open flag and the 16-bit backslash run), so state is ready
// for the next word each cycle. A result is registered in the output
// register, or in the one skid entry while the receiver stalls; i_in.ready
// drops only while the skid entry is full.
//
// Reset (i_rst_n low, synchronous) clears the parser state and empties the
// output stages. An end-of-line word also returns the parser to reset state.
// ----------------------------------------------------------------------------
module command_line_argument_splitter
    import clas_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    clas_stream_if.sink   i_in,
    clas_stream_if.source o_out
);

    // parser state
    logic        r_quoted, n_quoted;
    logic        r_qpend,  n_qpend;
    logic        r_arg_open, n_arg_open;
    logic [15:0] r_run,    n_run;

    // output stage and skid entry
    logic        r_out_v, r_skid_v;
    t_out_word   r_out,   r_skid;

    logic        in_acc;
    logic        out_take;
    logic        res_v;
    t_out_word   res;

    logic [15:0] cu;
    logic        is_ws;
    logic        quoted1;
    logic        quoted2;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_take = r_out_v && o_out.ready;
    assign i_in.ready  = !r_skid_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    assign cu      = i_in.data.code_unit;
    assign is_ws   = (cu == CU_SPACE) || (cu == CU_TAB);
    // a held quote that is not doubled closes the quoted section
    assign quoted1 = r_qpend ? 1'b0 : r_quoted;
    // a new argument always starts unquoted
    assign quoted2 = r_arg_open ? quoted1 : 1'b0;

    // one parse step
    always_comb begin
        n_quoted   = r_quoted;
        n_qpend    = r_qpend;
        n_arg_open = r_arg_open;
        n_run      = r_run;
        res_v      = 1'b0;
        res        = '0;

        priority if (i_in.data.line_end) begin
            res_v                 = 1'b1;
            res.backslash_count   = r_run;
            res.arg_done          = r_arg_open;
            res.line_done         = 1'b1;
            n_quoted              = 1'b0;
            n_qpend               = 1'b0;
            n_arg_open            = 1'b0;
            n_run                 = '0;
        end else if (r_qpend && cu == CU_QUOTE) begin
            // doubled quote inside quotes: literal quote, stay quoted
            n_qpend      = 1'b0;
            res_v        = 1'b1;
            res.has_char = 1'b1;
            res.out_char = CU_QUOTE;
        end else if (r_run != '0 && cu == CU_BSLASH) begin
            n_qpend  = 1'b0;
            n_quoted = quoted1;
            if (r_run != RUN_MAX) begin
                n_run = r_run + 16'd1;
            end
        end else if (r_run != '0 && cu == CU_QUOTE) begin
            // backslashes before a quote: halve, parity picks the meaning
            n_qpend             = 1'b0;
            n_run               = '0;
            res_v               = 1'b1;
            res.backslash_count = {1'b0, r_run[15:1]};
            if (r_run[0]) begin
                n_quoted     = quoted1;
                res.has_char = 1'b1;
                res.out_char = CU_QUOTE;
            end else begin
                n_quoted = !quoted1;
            end
        end else if (!r_arg_open && is_ws) begin
            // separator between arguments
            n_qpend  = 1'b0;
            n_quoted = quoted1;
            n_run    = '0;
        end else begin
            n_qpend    = 1'b0;
            n_quoted   = quoted2;
            n_arg_open = 1'b1;
            n_run      = '0;
            priority if (!quoted2 && is_ws) begin
                n_arg_open          = 1'b0;
                res_v               = 1'b1;
                res.backslash_count = r_run;
                res.arg_done        = 1'b1;
            end else if (cu == CU_BSLASH) begin
                n_run = 16'd1;
            end else if (cu == CU_QUOTE) begin
                if (quoted2) begin
                    n_qpend = 1'b1;
                end else begin
                    n_quoted = 1'b1;
                end
            end else begin
                res_v               = 1'b1;
                res.backslash_count = r_run;
                res.has_char        = 1'b1;
                res.out_char        = cu;
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted   <= 1'b0;
            r_qpend    <= 1'b0;
            r_arg_open <= 1'b0;
            r_run      <= '0;
        end else if (in_acc) begin
            r_quoted   <= n_quoted;
            r_qpend    <= n_qpend;
            r_arg_open <= n_arg_open;
            r_run      <= n_run;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (in_acc && res_v) begin
            if (!r_out_v || out_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc && res_v) begin
            if (!r_out_v || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid while output register empty");

    // a held quote only exists inside quotes, with no backslash run open
    a_qpend_quoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qpend |-> (r_quoted && r_run == '0))
        else $error("pending quote outside quotes or with open run");

    // an open backslash run belongs to an open argument
    a_run_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run != '0) |-> r_arg_open)
        else $error("backslash run outside an argument");

    // end of line returns the parser to reset state
    a_line_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.line_end) |=>
            (!r_quoted && !r_qpend && !r_arg_open && r_run == '0))
        else $error("parser state not cleared after end of line");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for command_line_argument_splitter
// A directed table walks empty lines, extreme code units, separators, quoting,
// doubled quotes, backslash runs before quotes and dropped pending quotes.
// Random command lines follow. Every accepted result word is compared field
// by field with the table's expected word or a local model of the splitting
// rules. The sender works in bursts, the receiver stalls on its own pattern
// and once holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top
    import clas_pkg::*;
();

    localparam int CYCLE_LIMIT   = 100_000;
    localparam int RANDOM_WORDS  = 1620;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    // receiver stall patterns
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    // one row of the directed table; r is used only when typed is set
    typedef struct packed {
        logic [15:0] cu;
        logic        le;
        bit          typed;
        bit          res;
        t_out_word   r;
    } t_dir_row;

    localparam t_out_word NO_RES = '0;

    localparam t_dir_row DIR_ROWS [25] = '{
        // empty line: only line_done; code unit ignored
        '{16'hFFFF, 1'b1, 1'b1, 1'b1, '{16'd0, 1'b0, 16'h0000, 1'b0, 1'b1}},
        // plain char, code unit zero, top code unit
        '{16'h0061, 1'b0, 1'b1, 1'b1, '{16'd0, 1'b1, 16'h0061, 1'b0, 1'b0}},
        '{16'h0000, 1'b0, 1'b1, 1'b1, '{16'd0, 1'b1, 16'h0000, 1'b0, 1'b0}},
        '{16'hFFFF, 1'b0, 1'b1, 1'b1, '{16'd0, 1'b1, 16'hFFFF, 1'b0, 1'b0}},
        // tab ends the argument, space between arguments is silent
        '{CU_TAB,   1'b0, 1'b1, 1'b1, '{16'd0, 1'b0, 16'h0000, 1'b1, 1'b0}},
        '{CU_SPACE, 1'b0, 1'b1, 1'b0, NO_RES},
        // empty quoted argument
        '{CU_QUOTE, 1'b0, 1'b1, 1'b0, NO_RES},
        '{CU_QUOTE, 1'b0, 1'b1, 1'b0, NO_RES},
        '{CU_SPACE, 1'b0, 1'b1, 1'b1, '{16'd0, 1'b0, 16'h0000, 1'b1, 1'b0}},
        // doubled quote inside quotes, then a quoted space
        '{CU_QUOTE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_QUOTE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_QUOTE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_SPACE, 1'b0, 1'b0, 1'b0, NO_RES},
        // even run before a quote, then odd run before a quote
        '{CU_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_QUOTE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_QUOTE,  1'b0, 1'b0, 1'b0, NO_RES},
        // backslash run passing through before a char
        '{CU_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{16'h0063,  1'b0, 1'b0, 1'b0, NO_RES},
        // open run flushed at line end
        '{CU_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{16'h0000,  1'b1, 1'b1, 1'b1, '{16'd1, 1'b0, 16'h0000, 1'b1, 1'b1}},
        // pending quote dropped at line end
        '{CU_QUOTE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{CU_QUOTE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{16'h0000,  1'b1, 1'b1, 1'b1, '{16'd0, 1'b0, 16'h0000, 1'b1, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    clas_stream_if #(.T(t_in_word))  in_if ();
    clas_stream_if #(.T(t_out_word)) out_if ();

    command_line_argument_splitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // splitter model state
    bit          ps_quoted     = 1'b0;
    bit          ps_quote_wait = 1'b0;
    bit          ps_arg_open   = 1'b0;
    logic [15:0] ps_run        = '0;

    t_out_word split_results_due [$];

    int  burst_left     = 0;
    int  words_sent     = 0;
    int  lines_sent     = 0;
    int  results_seen   = 0;
    int  fail_count     = 0;
    int  cycle_count    = 0;
    bit  hold_req       = 1'b0;
    bit  hold_done      = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one splitting step; returns 1 when the word yields a result
    function automatic bit msvcrt_split(input t_in_word w, output t_out_word r);
        logic [15:0] cnt;
        bit          ws;
        r = '0;
        if (w.line_end) begin
            r.backslash_count = ps_run;
            r.arg_done        = ps_arg_open;
            r.line_done       = 1'b1;
            ps_quoted         = 1'b0;
            ps_quote_wait     = 1'b0;
            ps_arg_open       = 1'b0;
            ps_run            = '0;
            return 1'b1;
        end
        // a held quote: doubled gives a literal quote, else quoting ends
        if (ps_quote_wait) begin
            ps_quote_wait = 1'b0;
            if (w.code_unit == CU_QUOTE) begin
                r.has_char = 1'b1;
                r.out_char = CU_QUOTE;
                return 1'b1;
            end
            ps_quoted = 1'b0;
        end
        // open backslash run: extend, or resolve against a quote
        if (ps_run != '0) begin
            if (w.code_unit == CU_BSLASH) begin
                if (ps_run != RUN_MAX)
                    ps_run = ps_run + 16'd1;
                return 1'b0;
            end
            if (w.code_unit == CU_QUOTE) begin
                r.backslash_count = ps_run >> 1;
                if (ps_run[0]) begin
                    r.has_char = 1'b1;
                    r.out_char = CU_QUOTE;
                end else begin
                    ps_quoted = !ps_quoted;
                end
                ps_run = '0;
                return 1'b1;
            end
        end
        cnt    = ps_run;
        ps_run = '0;
        ws     = (w.code_unit == CU_SPACE) || (w.code_unit == CU_TAB);
        if (!ps_arg_open) begin
            if (ws)
                return 1'b0;
            ps_arg_open = 1'b1;
            ps_quoted   = 1'b0;
        end
        if (!ps_quoted && ws) begin
            ps_arg_open       = 1'b0;
            r.backslash_count = cnt;
            r.arg_done        = 1'b1;
            return 1'b1;
        end
        if (w.code_unit == CU_BSLASH) begin
            ps_run = 16'd1;
            return 1'b0;
        end
        if (w.code_unit == CU_QUOTE) begin
            if (ps_quoted)
                ps_quote_wait = 1'b1;
            else
                ps_quoted = 1'b1;
            return 1'b0;
        end
        r.backslash_count = cnt;
        r.has_char        = 1'b1;
        r.out_char        = w.code_unit;
        return 1'b1;
    endfunction

    // offer one word in bursts, wait for the handshake, log what it yields
    task automatic send_word(input t_in_word w, input bit typed, input bit typed_res,
                             input t_out_word typed_word);
        t_out_word r;
        bit        got;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        got = msvcrt_split(w, r);
        if (typed) begin
            got = typed_res;
            r   = typed_word;
        end
        if (got)
            split_results_due.push_back(r);
        words_sent++;
        if (w.line_end)
            lines_sent++;
    endtask

    task automatic send_unit(input logic [15:0] cu);
        send_word(t_in_word'{code_unit: cu, line_end: 1'b0}, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic send_line_end();
        send_word(t_in_word'{code_unit: 16'($urandom_range(0, 65535)), line_end: 1'b1},
                  1'b0, 1'b0, NO_RES);
    endtask

    // random command line: chars, separators, quotes and short backslash runs
    task automatic send_random_line();
        int len;
        int pick;
        int run_len;
        len = $urandom_range(0, 24);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_unit(16'($urandom_range(0, 65535)));
            end else if (pick < 50) begin
                send_unit(CU_SPACE);
            end else if (pick < 55) begin
                send_unit(CU_TAB);
            end else if (pick < 72) begin
                send_unit(CU_QUOTE);
            end else begin
                run_len = $urandom_range(1, 5);
                repeat (run_len) send_unit(CU_BSLASH);
            end
        end
        send_line_end();
    endtask

    // receiver: stall segments, plus one long hold-off on request
    initial begin : rx_pacing
        t_rx_mode mode;
        int       seg_len;
        out_if.ready = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode    = t_rx_mode'($urandom_range(0, 2));
            seg_len = $urandom_range(16, 160);
            repeat (seg_len) begin
                case (mode)
                    RX_FREE:  out_if.ready <= 1'b1;
                    RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default:  out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word seen;
        bit        bad;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen = out_if.data;
            results_seen++;
            if (split_results_due.size() == 0) begin
                $error("unexpected result word: count %0d char %h arg_done %b line_done %b",
                       seen.backslash_count, seen.out_char, seen.arg_done, seen.line_done);
                fail_count++;
            end else begin
                want = split_results_due.pop_front();
                bad  = 1'b0;
                if (seen.backslash_count !== want.backslash_count) begin
                    $error("backslash_count: expected %0d, got %0d",
                           want.backslash_count, seen.backslash_count);
                    bad = 1'b1;
                end
                if (seen.has_char !== want.has_char) begin
                    $error("has_char: expected %b, got %b", want.has_char, seen.has_char);
                    bad = 1'b1;
                end
                if (seen.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, seen.out_char);
                    bad = 1'b1;
                end
                if (seen.arg_done !== want.arg_done) begin
                    $error("arg_done: expected %b, got %b", want.arg_done, seen.arg_done);
                    bad = 1'b1;
                end
                if (seen.line_done !== want.line_done) begin
                    $error("line_done: expected %b, got %b", want.line_done, seen.line_done);
                    bad = 1'b1;
                end
                if (bad)
                    fail_count++;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int rand_start;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIR_ROWS[i]) begin
            send_word(t_in_word'{code_unit: DIR_ROWS[i].cu, line_end: DIR_ROWS[i].le},
                      DIR_ROWS[i].typed, DIR_ROWS[i].res, DIR_ROWS[i].r);
        end

        // random lines; receiver takes its long hold-off meanwhile
        hold_req   = 1'b1;
        rand_start = words_sent;
        while (words_sent - rand_start < RANDOM_WORDS)
            send_random_line();
        in_if.valid <= 1'b0;

        while (split_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words in %0d lines: directed cases and random lines;",
                 words_sent, lines_sent);
        $display("%0d results checked, receiver held off %0d cycles once.",
                 results_seen, HOLD_CYCLES);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
